// ===== design/rcd_pkg.sv =====
// Shared types, constants and header sizing for the chunk stream deframer.
package rcd_pkg;

	localparam int unsigned CHANNELS_DEF = 320;
	localparam logic [23:0] CHUNK_RESET = 24'd128;
	localparam logic [23:0] TS_ESCAPE = 24'hFFFFFF;
	localparam logic [16:0] ID_BASE1 = 17'd64;

	typedef enum logic [2:0] {
		PH_BASIC,
		PH_ID1,
		PH_ID2A,
		PH_ID2B,
		PH_MSG,
		PH_RES,
		PH_EXT,
		PH_DATA
	} phase_t;

	typedef struct packed {
		logic [31:0] ts;
		logic [31:0] delta;
		logic [23:0] len;
		logic [23:0] left;
		logic [7:0]  mtype;
		logic [31:0] stream;
	} chan_t;

	localparam int unsigned CHAN_W = $bits(chan_t);

	typedef struct packed {
		chan_t       c;
		logic [23:0] rem;
	} fin_t;

	function automatic logic [3:0] hdr_len(input logic [1:0] fmt);
		logic [3:0] r;
		case (fmt)
			2'd0: r = 4'd11;
			2'd1: r = 4'd7;
			2'd2: r = 4'd3;
			default: r = 4'd0;
		endcase
		return r;
	endfunction

	function automatic fin_t finish_hdr(input chan_t c, input logic [23:0] mx);
		fin_t r;
		logic [23:0] rl;
		r.c = c;
		if (c.left != 24'd0) begin
			rl = c.left;
			r.c.left = 24'd0;
		end else begin
			rl = c.len;
		end
		if (rl > mx) begin
			r.c.left = rl - mx;
			rl = mx;
		end
		r.rem = rl;
		return r;
	endfunction

endpackage

// ===== design/rcd_ram.sv =====
// Generic single-write, single-read RAM with registered read data.
module rcd_ram #(
	parameter int unsigned WIDTH = 8,
	parameter int unsigned DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule

// ===== design/rtmp_chunk_deframer.sv =====
// Chunk stream deframer: byte-wide header parser, per-channel table, tagged payload out.
//
//  channel | handshake            | payload
//  cfg     | cfg_valid/cfg_ready  | max_chunk_size
//  in      | in_valid/in_ready    | in_byte
//  out     | out_valid/out_ready  | data_byte .. unknown_channel
//
// One byte per cycle while in_ready is high, but no byte in the table resolve
// phase: each completed header passes through it to read the channel table
// (format 3 after its basic header, formats 0..2 after the message header).
// After reset the table is swept to zero, one entry a cycle, with in_ready
// low until the sweep ends. Config is always ready.
// A stalled output holds its transfer; in_ready is low during the sweep, in the
// table read cycle, and when the output register is full and not being taken.
module rtmp_chunk_deframer #(
	parameter int unsigned CHANNELS = rcd_pkg::CHANNELS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_valid,
	output logic        cfg_ready,
	input  logic [23:0] max_chunk_size,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic [7:0]  in_byte,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [7:0]  data_byte,
	output logic        byte_valid,
	output logic [16:0] channel_id,
	output logic [31:0] msg_timestamp,
	output logic [23:0] msg_length,
	output logic [7:0]  msg_type,
	output logic [31:0] msg_stream,
	output logic        message_end,
	output logic        unknown_channel
);
	import rcd_pkg::*;

	localparam int unsigned AW = $clog2(CHANNELS);
	localparam logic [16:0] NCH = 17'(CHANNELS);
	localparam logic [AW-1:0] LAST = AW'(CHANNELS - 1);

	phase_t phase_q, nphase;
	chan_t cur_q, ncur, fc, prev, rdata;
	fin_t f;
	logic [16:0] id_q, nid;
	logic [1:0] fmt_q, nfmt;
	logic [3:0] idx_q, nidx, k1;
	logic [1:0] kk;
	logic [23:0] rem_q, nrem, mx_q;
	logic [23:0] raw;
	logic [AW-1:0] clr_q;
	logic clr_act_q, adv, take, step, fdo, twe, known;
	logic emit, e_valid, e_end;
	logic [7:0] e_byte;
	logic ram_we;
	logic [AW-1:0] ram_waddr;
	chan_t ram_wdata;

	assign adv = ~out_valid | out_ready;
	assign in_ready = ~clr_act_q & (phase_q != PH_RES) & adv;
	assign take = in_valid & in_ready;
	assign step = (phase_q == PH_RES) ? (adv & ~clr_act_q) : take;
	assign cfg_ready = 1'b1;
	assign known = id_q < NCH;
	assign prev = known ? rdata : '0;

	always_comb begin
		nphase = phase_q;
		ncur = cur_q;
		nid = id_q;
		nfmt = fmt_q;
		nidx = idx_q;
		nrem = rem_q;
		fc = cur_q;
		fdo = 1'b0;
		emit = 1'b0;
		e_byte = in_byte;
		e_valid = 1'b1;
		e_end = 1'b0;
		twe = 1'b0;
		f = '0;
		raw = cur_q.ts[23:0];
		k1 = idx_q + 4'd1;
		kk = 2'(idx_q - 4'd7);
		case (phase_q)
			PH_BASIC: begin
				nfmt = in_byte[7:6];
				if (in_byte[5:0] == 6'd0) begin
					nphase = PH_ID1;
				end else if (in_byte[5:0] == 6'd1) begin
					nphase = PH_ID2A;
				end else begin
					nid = {11'd0, in_byte[5:0]};
					nphase = (in_byte[7:6] == 2'd3) ? PH_RES : PH_MSG;
				end
			end
			PH_ID1: begin
				nid = {9'd0, in_byte} + ID_BASE1;
				nphase = (fmt_q == 2'd3) ? PH_RES : PH_MSG;
			end
			PH_ID2A: begin
				nid = {9'd0, in_byte} + ID_BASE1;
				nphase = PH_ID2B;
			end
			PH_ID2B: begin
				nid = id_q + {1'b0, in_byte, 8'd0};
				nphase = (fmt_q == 2'd3) ? PH_RES : PH_MSG;
			end
			PH_MSG: begin
				if (idx_q < 4'd3) begin
					ncur.ts = {8'd0, cur_q.ts[15:0], in_byte};
				end else if (idx_q < 4'd6) begin
					ncur.len = {cur_q.len[15:0], in_byte};
				end else if (idx_q == 4'd6) begin
					ncur.mtype = in_byte;
				end else if (idx_q < 4'd11) begin
					ncur.stream[{kk, 3'b000} +: 8] = in_byte;
				end
				nidx = k1;
				if (k1 >= hdr_len(fmt_q)) begin
					nphase = PH_RES;
				end
			end
			PH_RES: begin
				if (fmt_q == 2'd3) begin
					fc = prev;
					fc.ts = (prev.left != 24'd0) ? prev.ts : prev.ts + prev.delta;
					fdo = 1'b1;
				end else begin
					fc = cur_q;
					if (fmt_q == 2'd0) begin
						fc.delta = {8'd0, raw};
						fc.left = 24'd0;
					end else begin
						if (raw != TS_ESCAPE) begin
							fc.delta = {8'd0, raw};
							fc.ts = prev.ts + {8'd0, raw};
						end
						fc.stream = prev.stream;
						if (fmt_q == 2'd1) begin
							fc.left = 24'd0;
						end else begin
							fc.len = prev.len;
							fc.left = prev.left;
							fc.mtype = prev.mtype;
						end
					end
					if (raw == TS_ESCAPE) begin
						fc.ts = 32'd0;
						ncur = fc;
						nphase = PH_EXT;
						nidx = 4'd0;
					end else begin
						fdo = 1'b1;
					end
				end
			end
			PH_EXT: begin
				ncur.ts[{idx_q[1:0], 3'b000} +: 8] = in_byte;
				nidx = k1;
				if (idx_q[1:0] == 2'd3) begin
					fc = ncur;
					fc.delta = ncur.ts;
					fdo = 1'b1;
				end
			end
			PH_DATA: begin
				nrem = rem_q - 24'd1;
				emit = 1'b1;
				if (nrem == 24'd0) begin
					e_end = (cur_q.left == 24'd0);
					nphase = PH_BASIC;
				end
			end
			default: begin
				nphase = PH_BASIC;
				nidx = 4'd0;
			end
		endcase
		if (fdo) begin
			f = finish_hdr(fc, mx_q);
			ncur = f.c;
			nrem = f.rem;
			nidx = 4'd0;
			twe = known;
			if (f.rem == 24'd0) begin
				nphase = PH_BASIC;
				emit = 1'b1;
				e_byte = 8'd0;
				e_valid = 1'b0;
				e_end = 1'b1;
			end else begin
				nphase = PH_DATA;
			end
		end
		if (phase_q == PH_BASIC || phase_q == PH_ID1 || phase_q == PH_ID2B) begin
			if (nphase == PH_MSG) begin
				ncur.ts = 32'd0;
				ncur.len = 24'd0;
				ncur.mtype = 8'd0;
				ncur.stream = 32'd0;
				nidx = 4'd0;
			end
		end
	end

	assign ram_we = clr_act_q | (twe & step);
	assign ram_waddr = clr_act_q ? clr_q : id_q[AW-1:0];
	assign ram_wdata = clr_act_q ? '0 : f.c;

	rcd_ram #(
		.WIDTH(CHAN_W),
		.DEPTH(CHANNELS)
	) u_table (
		.clk(clk),
		.we(ram_we),
		.waddr(ram_waddr),
		.wdata(ram_wdata),
		.raddr(nid[AW-1:0]),
		.rdata(rdata)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q <= PH_BASIC;
			cur_q <= '0;
			id_q <= '0;
			fmt_q <= '0;
			idx_q <= '0;
			rem_q <= '0;
			mx_q <= CHUNK_RESET;
			clr_q <= '0;
			clr_act_q <= 1'b1;
			out_valid <= 1'b0;
		end else begin
			if (cfg_valid) begin
				mx_q <= max_chunk_size;
			end
			if (clr_act_q) begin
				clr_q <= clr_q + AW'(1);
				if (clr_q == LAST) begin
					clr_act_q <= 1'b0;
				end
			end
			if (step) begin
				phase_q <= nphase;
				cur_q <= ncur;
				id_q <= nid;
				fmt_q <= nfmt;
				idx_q <= nidx;
				rem_q <= nrem;
			end
			if (step && emit) begin
				out_valid <= 1'b1;
			end else if (out_ready) begin
				out_valid <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (step && emit) begin
			data_byte <= e_byte;
			byte_valid <= e_valid;
			channel_id <= nid;
			msg_timestamp <= ncur.ts;
			msg_length <= ncur.len;
			msg_type <= ncur.mtype;
			msg_stream <= ncur.stream;
			message_end <= e_end;
			unknown_channel <= ~(nid < NCH);
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) clr_act_q |-> !in_ready)
		else $error("input taken during table sweep");
	assert property (@(posedge clk) disable iff (!arst_n)
		(phase_q == PH_RES && step) |=> phase_q != PH_RES)
		else $error("table resolve lasted more than one step");
	assert property (@(posedge clk) disable iff (!arst_n)
		(twe && step) |-> !clr_act_q)
		else $error("channel update collides with sweep");
	assert property (@(posedge clk) disable iff (!arst_n)
		(step && emit) |=> out_valid)
		else $error("emitted transfer lost");
endmodule

// ===== bench/tb.sv =====
// Testbench for rtmp_chunk_deframer: directed and random chunk streams checked against a predictor.
module tb;
	import rcd_pkg::*;

	localparam int CH = CHANNELS_DEF;

	typedef struct packed {
		logic [7:0]  data;
		logic        bval;
		logic [16:0] id;
		logic [31:0] ts;
		logic [23:0] len;
		logic [7:0]  typ;
		logic [31:0] strm;
		logic        mend;
		logic        unk;
	} pay_t;

	typedef struct {
		logic [1:0]  fmt;
		int          form;
		logic [16:0] id;
		logic [23:0] ts;
		logic [31:0] ext;
		logic [23:0] len;
		logic [7:0]  typ;
		logic [31:0] strm;
		bit          typed;
		pay_t        res;
	} chunk_row_t;

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        cfg_valid = 1'b0;
	logic        cfg_ready;
	logic [23:0] cfg_data = '0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic [7:0]  in_byte = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	pay_t        got;

	rtmp_chunk_deframer i_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .max_chunk_size(cfg_data),
		.in_valid(in_valid), .in_ready(in_ready), .in_byte(in_byte),
		.out_valid(out_valid), .out_ready(out_ready),
		.data_byte(got.data), .byte_valid(got.bval), .channel_id(got.id),
		.msg_timestamp(got.ts), .msg_length(got.len), .msg_type(got.typ),
		.msg_stream(got.strm), .message_end(got.mend), .unknown_channel(got.unk)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	logic [31:0] t_ts [CH];
	logic [31:0] t_delta [CH];
	logic [23:0] t_len [CH];
	logic [23:0] t_left [CH];
	logic [7:0]  t_typ [CH];
	logic [31:0] t_strm [CH];
	logic [31:0] c_ts, c_delta, c_strm, p_ts, p_delta, p_strm;
	logic [23:0] c_len, c_left, p_len, p_left, chunk_rem, chunk_max;
	logic [7:0]  c_typ, p_typ;
	logic [16:0] c_id;
	logic [1:0]  c_fmt;
	phase_t      parse_ph;
	int          hdr_idx;

	pay_t  pending_q[$];
	byte unsigned tx_q[$];
	int    errors = 0;
	int    n_results = 0;
	int    n_sent = 0;
	bit    no_gaps = 0;

	task automatic report(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		errors++;
	endtask

	task automatic chk(input string f, input logic [31:0] g, input logic [31:0] e);
		if (g !== e)
			report($sformatf("%s got %h want %h", f, g, e));
	endtask

	function automatic pay_t tag(input logic [7:0] b, input logic v, input logic e);
		return '{b, v, c_id, c_ts, c_len, c_typ, c_strm, e, c_id >= CH};
	endfunction

	task automatic load_prev();
		bit kn;
		kn = c_id < CH;
		p_ts = kn ? t_ts[c_id] : '0;
		p_delta = kn ? t_delta[c_id] : '0;
		p_len = kn ? t_len[c_id] : '0;
		p_left = kn ? t_left[c_id] : '0;
		p_typ = kn ? t_typ[c_id] : '0;
		p_strm = kn ? t_strm[c_id] : '0;
	endtask

	task automatic close_header(output bit has, output pay_t r);
		logic [23:0] csz;
		if (c_left != 0) begin
			csz = c_left;
			c_left = 0;
		end else begin
			csz = c_len;
		end
		if (csz > chunk_max) begin
			c_left = csz - chunk_max;
			csz = chunk_max;
		end
		if (c_id < CH) begin
			t_ts[c_id] = c_ts;
			t_delta[c_id] = c_delta;
			t_len[c_id] = c_len;
			t_left[c_id] = c_left;
			t_typ[c_id] = c_typ;
			t_strm[c_id] = c_strm;
		end
		chunk_rem = csz;
		hdr_idx = 0;
		has = 0;
		if (chunk_rem == 0) begin
			parse_ph = PH_BASIC;
			has = 1;
			r = tag(8'd0, 1'b0, 1'b1);
		end else begin
			parse_ph = PH_DATA;
		end
	endtask

	task automatic basic_seen(output bit has, output pay_t r);
		has = 0;
		if (c_fmt == 2'd3) begin
			load_prev();
			c_delta = p_delta;
			c_len = p_len;
			c_left = p_left;
			c_typ = p_typ;
			c_strm = p_strm;
			c_ts = (p_left > 0) ? p_ts : p_ts + p_delta;
			close_header(has, r);
		end else begin
			c_ts = 0;
			c_len = 0;
			c_typ = 0;
			c_strm = 0;
			parse_ph = PH_MSG;
			hdr_idx = 0;
		end
	endtask

	task automatic deframe_byte(input logic [7:0] b, output bit has, output pay_t r);
		logic [23:0] raw;
		int hl;
		has = 0;
		case (parse_ph)
			PH_BASIC: begin
				c_fmt = b[7:6];
				if (b[5:0] == 0) parse_ph = PH_ID1;
				else if (b[5:0] == 1) parse_ph = PH_ID2A;
				else begin
					c_id = {11'd0, b[5:0]};
					basic_seen(has, r);
				end
			end
			PH_ID1: begin
				c_id = 17'(b) + 17'd64;
				basic_seen(has, r);
			end
			PH_ID2A: begin
				c_id = 17'(b) + 17'd64;
				parse_ph = PH_ID2B;
			end
			PH_ID2B: begin
				c_id = c_id + 17'(b) * 17'd256;
				basic_seen(has, r);
			end
			PH_MSG: begin
				if (hdr_idx < 3) c_ts = {8'd0, c_ts[15:0], b};
				else if (hdr_idx < 6) c_len = {c_len[15:0], b};
				else if (hdr_idx == 6) c_typ = b;
				else if (hdr_idx < 11) c_strm = c_strm | (32'(b) << (8 * (hdr_idx - 7)));
				hdr_idx++;
				hl = (c_fmt == 0) ? 11 : (c_fmt == 1) ? 7 : 3;
				if (hdr_idx >= hl) begin
					load_prev();
					raw = c_ts[23:0];
					if (c_fmt == 0) begin
						c_delta = raw;
						c_left = 0;
					end else begin
						if (raw != TS_ESCAPE) begin
							c_delta = raw;
							c_ts = p_ts + raw;
						end
						c_strm = p_strm;
						if (c_fmt == 1) c_left = 0;
						else begin
							c_len = p_len;
							c_left = p_left;
							c_typ = p_typ;
						end
					end
					if (raw == TS_ESCAPE) begin
						parse_ph = PH_EXT;
						hdr_idx = 0;
						c_ts = 0;
					end else begin
						close_header(has, r);
					end
				end
			end
			PH_EXT: begin
				c_ts = c_ts | (32'(b) << (8 * (hdr_idx & 3)));
				hdr_idx++;
				if (hdr_idx >= 4) begin
					c_delta = c_ts;
					close_header(has, r);
				end
			end
			PH_DATA: begin
				if (chunk_rem > 0) chunk_rem--;
				has = 1;
				r = tag(b, 1'b1, 1'b0);
				if (chunk_rem == 0) begin
					r.mend = (c_left == 0);
					parse_ph = PH_BASIC;
				end
			end
			default: begin
				parse_ph = PH_BASIC;
				hdr_idx = 0;
			end
		endcase
	endtask

	task automatic put(input logic [7:0] b);
		bit has;
		pay_t r;
		tx_q.push_back(b);
		deframe_byte(b, has, r);
		if (has)
			pending_q.push_back(r);
	endtask

	task automatic build_chunk(input logic [1:0] fmt, input int form, input logic [16:0] id,
			input logic [23:0] ts, input logic [31:0] ext, input logic [23:0] len,
			input logic [7:0] typ, input logic [31:0] strm);
		logic [16:0] hi;
		hi = id - 17'd64;
		if (form == 0) put({fmt, id[5:0]});
		else if (form == 1) begin
			put({fmt, 6'd0});
			put(hi[7:0]);
		end else begin
			put({fmt, 6'd1});
			put(hi[7:0]);
			put(hi[15:8]);
		end
		if (fmt <= 2) begin
			put(ts[23:16]);
			put(ts[15:8]);
			put(ts[7:0]);
		end
		if (fmt <= 1) begin
			put(len[23:16]);
			put(len[15:8]);
			put(len[7:0]);
			put(typ);
		end
		if (fmt == 0)
			for (int i = 0; i < 4; i++) put(strm[8*i +: 8]);
		if (fmt <= 2 && ts == TS_ESCAPE)
			for (int i = 0; i < 4; i++) put(ext[8*i +: 8]);
		while (parse_ph != PH_BASIC)
			put(8'($urandom_range(0, 255)));
	endtask

	function automatic int pick_gap();
		int r;
		r = $urandom_range(0, 99);
		if (no_gaps || r < 55) return 0;
		if (r < 92) return $urandom_range(1, 3);
		return $urandom_range(5, 30);
	endfunction

	task automatic send_bytes();
		int g;
		while (tx_q.size() > 0) begin
			g = pick_gap();
			if (g > 0) begin
				in_valid <= 1'b0;
				repeat (g) @(posedge clk);
			end
			in_valid <= 1'b1;
			in_byte <= tx_q.pop_front();
			do @(posedge clk); while (!in_ready);
			n_sent++;
		end
	endtask

	task automatic drain();
		in_valid <= 1'b0;
		while (pending_q.size() > 0) @(posedge clk);
		repeat (10) @(posedge clk);
	endtask

	task automatic set_chunk_size(input logic [23:0] v);
		drain();
		cfg_valid <= 1'b1;
		cfg_data <= v;
		do @(posedge clk); while (!cfg_ready);
		cfg_valid <= 1'b0;
		chunk_max = v;
	endtask

	task automatic random_chunk();
		logic [16:0] pool [11] = '{2, 3, 4, 5, 63, 64, 100, 319, 320, 1000, 65599};
		logic [16:0] id;
		logic [1:0]  fmt;
		logic [23:0] ts, len;
		int form, r;
		id = pool[$urandom_range(0, 10)];
		r = $urandom_range(0, 99);
		if (id < CH && t_left[id] > 0)
			fmt = (r < 70) ? 2'd3 : (r < 80) ? 2'd2 : (r < 90) ? 2'd1 : 2'd0;
		else
			fmt = (r < 40) ? 2'd0 : (r < 60) ? 2'd1 : (r < 75) ? 2'd2 : 2'd3;
		if (chunk_max > 128 && id < CH && (t_left[id] > 300 || t_len[id] > 300))
			fmt = 2'd0;
		if (id < 64) form = 0;
		else if (id < CH) form = $urandom_range(1, 2);
		else form = 2;
		r = $urandom_range(0, 7);
		ts = (r == 0) ? TS_ESCAPE : (r == 1) ? 24'($urandom_range(0, 20)) : 24'($urandom);
		r = $urandom_range(0, 9);
		len = (r == 0) ? 24'd0 : (r < 8) ? 24'($urandom_range(1, 40))
			: 24'($urandom_range(41, 300));
		if (chunk_max <= 128 && $urandom_range(0, 19) == 0)
			repeat ($urandom_range(1, 3)) put(8'($urandom_range(0, 255)));
		while (parse_ph != PH_BASIC)
			put(8'($urandom_range(0, 255)));
		build_chunk(fmt, form, id, ts, $urandom, len, 8'($urandom), $urandom);
	endtask

	initial begin
		pay_t e;
		int hold, low;
		bit held;
		hold = 0;
		low = 0;
		held = 0;
		forever begin
			@(posedge clk);
			if (out_valid && out_ready) begin
				n_results++;
				if (pending_q.size() == 0) report("result with nothing pending");
				else begin
					e = pending_q.pop_front();
					chk("data_byte", got.data, e.data);
					chk("byte_valid", got.bval, e.bval);
					chk("channel_id", got.id, e.id);
					chk("msg_timestamp", got.ts, e.ts);
					chk("msg_length", got.len, e.len);
					chk("msg_type", got.typ, e.typ);
					chk("msg_stream", got.strm, e.strm);
					chk("message_end", got.mend, e.mend);
					chk("unknown_channel", got.unk, e.unk);
				end
			end
			if (hold > 0) begin
				hold--;
				out_ready <= 1'b0;
			end else if (!held && n_results >= 60) begin
				held = 1;
				hold = 400;
				out_ready <= 1'b0;
			end else if (low > 0) begin
				low--;
				out_ready <= 1'b0;
			end else begin
				case ($urandom_range(0, 99)) inside
					[0:7]: begin
						low = $urandom_range(0, 2);
						out_ready <= 1'b0;
					end
					[8:9]: begin
						low = $urandom_range(10, 40);
						out_ready <= 1'b0;
					end
					default: out_ready <= 1'b1;
				endcase
			end
		end
	end

	initial begin
		chunk_row_t dir_tab [17];
		logic [23:0] sizes [6];
		int start, chunks;
		sizes = '{24'd1, 24'd7, 24'hFFFFFF, 24'd0, 24'd128, 24'd2};
		for (int i = 0; i < CH; i++) begin
			t_ts[i] = 0; t_delta[i] = 0; t_len[i] = 0;
			t_left[i] = 0; t_typ[i] = 0; t_strm[i] = 0;
		end
		c_ts = 0; c_delta = 0; c_strm = 0; c_len = 0; c_left = 0; c_typ = 0;
		c_id = 0; c_fmt = 0; parse_ph = PH_BASIC; hdr_idx = 0; chunk_rem = 0;
		chunk_max = CHUNK_RESET;
		dir_tab = '{
			'{0, 0, 2, 0, 0, 0, 0, 0, 1, '{0, 0, 2, 0, 0, 0, 0, 1, 0}},
			'{0, 0, 63, 24'hFFFFFE, 0, 3, 8'hFF, 32'hFFFFFFFF, 0, '0},
			'{1, 0, 63, 5, 0, 2, 9, 0, 0, '0},
			'{2, 0, 63, 7, 0, 0, 0, 0, 0, '0},
			'{3, 0, 63, 0, 0, 0, 0, 0, 0, '0},
			'{0, 0, 2, TS_ESCAPE, 32'h12345678, 4, 8, 1, 0, '0},
			'{1, 0, 2, TS_ESCAPE, 32'hFFFFFFFF, 2, 20, 0, 0, '0},
			'{3, 0, 2, 0, 0, 0, 0, 0, 0, '0},
			'{0, 1, 64, 0, 0, 0, 0, 0, 1, '{0, 0, 64, 0, 0, 0, 0, 1, 0}},
			'{0, 2, 65599, 1, 0, 1, 1, 0, 0, '0},
			'{3, 2, 65599, 0, 0, 0, 0, 0, 1, '{0, 0, 65599, 0, 0, 0, 0, 1, 1}},
			'{1, 1, 100, 3, 0, 1, 5, 0, 0, '0},
			'{2, 0, 11, 5, 0, 0, 0, 0, 1, '{0, 0, 11, 5, 0, 0, 0, 1, 0}},
			'{0, 2, 319, 0, 0, 300, 1, 32'h80000000, 0, '0},
			'{2, 1, 319, 1, 0, 0, 0, 0, 0, '0},
			'{3, 2, 319, 0, 0, 0, 0, 0, 0, '0},
			'{0, 2, 320, 16, 0, 0, 7, 32'h55, 1, '{0, 0, 320, 16, 0, 7, 32'h55, 1, 1}}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		foreach (dir_tab[i]) begin
			build_chunk(dir_tab[i].fmt, dir_tab[i].form, dir_tab[i].id, dir_tab[i].ts,
				dir_tab[i].ext, dir_tab[i].len, dir_tab[i].typ, dir_tab[i].strm);
			if (dir_tab[i].typed) begin
				void'(pending_q.pop_back());
				pending_q.push_back(dir_tab[i].res);
			end
			send_bytes();
		end
		foreach (sizes[s]) begin
			set_chunk_size(sizes[s]);
			start = n_sent;
			chunks = 0;
			while ((sizes[s] == 0) ? chunks < 12 : n_sent - start < 60) begin
				no_gaps = ($urandom_range(0, 3) == 0);
				random_chunk();
				send_bytes();
				chunks++;
				if (chunks % 25 == 0) drain();
			end
		end
		drain();
		repeat (40) @(posedge clk);
		if (errors == 0 && pending_q.size() == 0)
			$display("All tests passed");
		else
			$display("Some tests failed");
		$finish;
	end

	initial begin
		#8000000;
		$display("Some tests failed");
		$finish;
	end

endmodule
